@@ sv/fvar_pkg.sv @@
// ----------------------------------------------------------------------------
// fvar_pkg
// Shared widths, codes and limits of the fence voltage alarm reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package fvar_pkg;

    localparam int MV_W       = 12;
    localparam int KV_W       = 24;
    localparam int GAIN_W     = 24;
    localparam int SINT_W     = 16;
    localparam int RINT_W     = 24;
    localparam int TALLY_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = MV_W + GAIN_W;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = PROD_W - FRAC_W + 2;

    localparam logic signed [KV_W-1:0] KV_MAX = {1'b0, {(KV_W-1){1'b1}}};
    localparam logic signed [KV_W-1:0] KV_MIN = {1'b1, {(KV_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_LOW    = 2'd1,
        ST_DOWN   = 2'd2
    } t_status;

    typedef enum logic {
        REQ_SAMPLE  = 1'b0,
        REQ_PUBLISH = 1'b1
    } t_req;

    typedef enum logic {
        RES_WINDOW  = 1'b0,
        RES_PUBLISH = 1'b1
    } t_res_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_GAIN        = 3'd0,
        CFG_CAL_OFFSET      = 3'd1,
        CFG_DOWN_THRESHOLD  = 3'd2,
        CFG_LOW_THRESHOLD   = 3'd3,
        CFG_SAMPLE_INTERVAL = 3'd4,
        CFG_REPORT_INTERVAL = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

@@ sv/fvar_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fvar_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvar_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fvar_pkg::CFG_IDX_W-1:0]    index;
    logic [fvar_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/fvar_in_if.sv @@
// ----------------------------------------------------------------------------
// fvar_in_if
// Request channel: adc samples and publish outcomes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvar_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [fvar_pkg::MV_W-1:0]   sample_mv;
    logic                        window_last;
    logic                        publish_ok;

    modport source (output valid, output req_type, output sample_mv,
                    output window_last, output publish_ok, input ready);
    modport sink   (input valid, input req_type, input sample_mv,
                    input window_last, input publish_ok, output ready);
endinterface

`default_nettype wire

@@ sv/fvar_out_if.sv @@
// ----------------------------------------------------------------------------
// fvar_out_if
// Result channel: window evaluations and publish acknowledgments.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvar_out_if;
    logic                               valid;
    logic                               ready;
    logic                               result_kind;
    logic [fvar_pkg::MV_W-1:0]          peak_mv;
    logic signed [fvar_pkg::KV_W-1:0]   fence_kv;
    logic [1:0]                         fence_status;
    logic                               report_now;
    logic                               report_due;
    logic                               status_change;
    logic [fvar_pkg::TALLY_W-1:0]       failed_count;

    modport source (output valid, output result_kind, output peak_mv, output fence_kv,
                    output fence_status, output report_now, output report_due,
                    output status_change, output failed_count, input ready);
    modport sink   (input valid, input result_kind, input peak_mv, input fence_kv,
                    input fence_status, input report_now, input report_due,
                    input status_change, input failed_count, output ready);
endinterface

`default_nettype wire

@@ sv/fence_voltage_alarm_reporter.sv @@
// ----------------------------------------------------------------------------
// fence_voltage_alarm_reporter
// Tracks the peak of each sample window, converts it to kilovolts, classifies
// it against two thresholds and decides when a report must go out. Each request
// beat passes an input register, a register after the
// 12x24 peak times gain multiply, and the result register after the offset
// add, saturation, threshold compares and report decision. Non-last samples
// and publish outcomes with no report pending give no result. A stalled result
// stage holds the pipe back; with the result side ready the block sustains one
// request per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module fence_voltage_alarm_reporter #(
    parameter int ADC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fvar_cfg_if.sink    i_cfg,
    fvar_in_if.sink     i_in,
    fvar_out_if.source  o_res
);

    localparam int MvW      = fvar_pkg::MV_W;
    localparam int KvW      = fvar_pkg::KV_W;
    localparam int ProdW    = fvar_pkg::PROD_W;
    localparam int SumW     = fvar_pkg::SUM_W;
    localparam int TallyW   = fvar_pkg::TALLY_W;
    localparam int RintW    = fvar_pkg::RINT_W;
    localparam int SintW    = fvar_pkg::SINT_W;
    localparam int MaskBits = (ADC_BITS < MvW) ? ADC_BITS : MvW;
    localparam logic [MvW-1:0] AdcMask = {MvW{1'b1}} >> (MvW - MaskBits);

    // configuration registers
    logic [fvar_pkg::GAIN_W-1:0] r_cal_gain;
    logic signed [KvW-1:0]       r_cal_offset;
    logic signed [KvW-1:0]       r_down_thr;
    logic signed [KvW-1:0]       r_low_thr;
    logic [SintW-1:0]            r_sample_int;
    logic [RintW-1:0]            r_report_int;

    // input stage
    logic               r_v0;
    fvar_pkg::t_req     r0_req;
    logic [MvW-1:0]     r0_mv;
    logic               r0_last;
    logic               r0_ok;

    // product stage
    logic               r_v1;
    fvar_pkg::t_req     r1_req;
    logic               r1_ok;
    logic [MvW-1:0]     r1_peak;
    logic [ProdW-1:0]   r1_prod;

    // block state
    logic [MvW-1:0]     r_run_peak;
    logic [RintW-1:0]   r_elapsed;
    fvar_pkg::t_status  r_rep_status;
    fvar_pkg::t_status  r_pend_status;
    logic               r_pending;
    logic [TallyW-1:0]  r_tally;

    // result register
    logic                       r_ov;
    fvar_pkg::t_res_kind        r_o_kind;
    logic [MvW-1:0]             r_o_peak;
    logic signed [KvW-1:0]      r_o_kv;
    fvar_pkg::t_status          r_o_status;
    logic                       r_o_now;
    logic                       r_o_due;
    logic                       r_o_edge;
    logic [TallyW-1:0]          r_o_tally;

    logic               adv0;
    logic               adv1;
    logic               s1_free;
    logic               emit;
    logic [MvW-1:0]     mv_m;
    logic [MvW-1:0]     s0_peak;
    logic [ProdW-1:0]   s0_prod;
    logic signed [SumW-1:0] kv_sum;
    logic signed [KvW-1:0]  kv_sat;
    fvar_pkg::t_status  status;
    logic [RintW:0]     el_sum;
    logic [RintW-1:0]   el_add;
    logic               due;
    logic               edge_flag;
    logic               now_flag;
    logic [TallyW-1:0]  tally_inc;

    logic [RintW-1:0]   n_elapsed;
    fvar_pkg::t_status  n_rep_status;
    fvar_pkg::t_status  n_pend_status;
    logic               n_pending;
    logic [TallyW-1:0]  n_tally;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_gain   <= fvar_pkg::GAIN_W'(256);
            r_cal_offset <= '0;
            r_down_thr   <= KvW'(512);
            r_low_thr    <= KvW'(1024);
            r_sample_int <= SintW'(60);
            r_report_int <= RintW'(900);
        end else if (i_cfg.valid) begin
            unique case (fvar_pkg::t_cfg_idx'(i_cfg.index))
                fvar_pkg::CFG_CAL_GAIN:        r_cal_gain   <= i_cfg.data;
                fvar_pkg::CFG_CAL_OFFSET:      r_cal_offset <= i_cfg.data;
                fvar_pkg::CFG_DOWN_THRESHOLD:  r_down_thr   <= i_cfg.data;
                fvar_pkg::CFG_LOW_THRESHOLD:   r_low_thr    <= i_cfg.data;
                fvar_pkg::CFG_SAMPLE_INTERVAL: r_sample_int <= i_cfg.data[SintW-1:0];
                fvar_pkg::CFG_REPORT_INTERVAL: r_report_int <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow
    // ------------------------------------------------------------------
    assign adv1       = r_v1 && (!r_ov || o_res.ready);
    assign s1_free    = !r_v1 || adv1;
    assign adv0       = r_v0 && s1_free;
    assign i_in.ready = !r_v0 || adv0;

    // ------------------------------------------------------------------
    // input stage: peak tracking and multiply
    // ------------------------------------------------------------------
    assign mv_m    = r0_mv & AdcMask;
    assign s0_peak = (mv_m > r_run_peak) ? mv_m : r_run_peak;
    assign s0_prod = ProdW'(s0_peak) * ProdW'(r_cal_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_run_peak <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_v0 <= 1'b1;
            end else if (adv0) begin
                r_v0 <= 1'b0;
            end
            // non-last samples stop here
            if (adv0) begin
                r_v1 <= (r0_req == fvar_pkg::REQ_PUBLISH) || r0_last;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv0 && r0_req == fvar_pkg::REQ_SAMPLE) begin
                r_run_peak <= r0_last ? '0 : s0_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r0_req  <= fvar_pkg::t_req'(i_in.req_type);
            r0_mv   <= i_in.sample_mv;
            r0_last <= i_in.window_last;
            r0_ok   <= i_in.publish_ok;
        end
        if (adv0) begin
            r1_req  <= r0_req;
            r1_ok   <= r0_ok;
            r1_peak <= s0_peak;
            r1_prod <= s0_prod;
        end
    end

    // ------------------------------------------------------------------
    // evaluation stage
    // ------------------------------------------------------------------
    assign kv_sum = $signed({2'b00, r1_prod[ProdW-1:fvar_pkg::FRAC_W]})
                  + $signed({{(SumW-KvW){r_cal_offset[KvW-1]}}, r_cal_offset});

    always_comb begin
        priority if (kv_sum > $signed({{(SumW-KvW){1'b0}}, fvar_pkg::KV_MAX})) begin
            kv_sat = fvar_pkg::KV_MAX;
        end else if (kv_sum < $signed({{(SumW-KvW){1'b1}}, fvar_pkg::KV_MIN})) begin
            kv_sat = fvar_pkg::KV_MIN;
        end else begin
            kv_sat = kv_sum[KvW-1:0];
        end
    end

    always_comb begin
        priority if (kv_sat < r_down_thr) begin
            status = fvar_pkg::ST_DOWN;
        end else if (kv_sat < r_low_thr) begin
            status = fvar_pkg::ST_LOW;
        end else begin
            status = fvar_pkg::ST_NORMAL;
        end
    end

    assign el_sum    = {1'b0, r_elapsed} + (RintW+1)'(r_sample_int);
    assign el_add    = el_sum[RintW] ? {RintW{1'b1}} : el_sum[RintW-1:0];
    assign due       = el_add >= r_report_int;
    assign edge_flag = status != r_rep_status;
    assign now_flag  = due || edge_flag;
    assign tally_inc = (&r_tally) ? r_tally : r_tally + TallyW'(1);
    assign emit      = (r1_req == fvar_pkg::REQ_SAMPLE) || r_pending;

    always_comb begin
        n_elapsed     = r_elapsed;
        n_rep_status  = r_rep_status;
        n_pend_status = r_pend_status;
        n_pending     = r_pending;
        n_tally       = r_tally;
        if (adv1) begin
            if (r1_req == fvar_pkg::REQ_SAMPLE) begin
                n_elapsed     = el_add;
                n_pending     = now_flag;
                n_pend_status = status;
            end else if (r_pending) begin
                n_pending = 1'b0;
                if (r1_ok) begin
                    n_elapsed    = '0;
                    n_rep_status = r_pend_status;
                end else begin
                    n_tally = tally_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= {RintW{1'b1}};
            r_rep_status  <= fvar_pkg::ST_NORMAL;
            r_pend_status <= fvar_pkg::ST_NORMAL;
            r_pending     <= 1'b0;
            r_tally       <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_elapsed     <= n_elapsed;
            r_rep_status  <= n_rep_status;
            r_pend_status <= n_pend_status;
            r_pending     <= n_pending;
            r_tally       <= n_tally;
            if (adv1 && emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && emit) begin
            if (r1_req == fvar_pkg::REQ_SAMPLE) begin
                r_o_kind   <= fvar_pkg::RES_WINDOW;
                r_o_peak   <= r1_peak;
                r_o_kv     <= kv_sat;
                r_o_status <= status;
                r_o_now    <= now_flag;
                r_o_due    <= due;
                r_o_edge   <= edge_flag;
                r_o_tally  <= r_tally;
            end else begin
                r_o_kind   <= fvar_pkg::RES_PUBLISH;
                r_o_peak   <= '0;
                r_o_kv     <= '0;
                r_o_status <= r_pend_status;
                r_o_now    <= 1'b0;
                r_o_due    <= 1'b0;
                r_o_edge   <= 1'b0;
                r_o_tally  <= n_tally;
            end
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.result_kind   = r_o_kind;
    assign o_res.peak_mv       = r_o_peak;
    assign o_res.fence_kv      = r_o_kv;
    assign o_res.fence_status  = r_o_status;
    assign o_res.report_now    = r_o_now;
    assign o_res.report_due    = r_o_due;
    assign o_res.status_change = r_o_edge;
    assign o_res.failed_count  = r_o_tally;

`ifndef SYNTHESIS
    a_now_is_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_kind == fvar_pkg::RES_WINDOW) |-> (r_o_now == (r_o_due || r_o_edge)))
        else $error("report_now differs from due or status change");

    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_kind == fvar_pkg::RES_PUBLISH) |-> (r_o_kv == '0 && !r_o_now))
        else $error("publish acknowledgment carries window data");

    a_tally_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_tally >= $past(r_tally)))
        else $error("failure tally went down");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && r1_req == fvar_pkg::REQ_PUBLISH && r_pending && r1_ok)
        |=> (r_elapsed == '0 && !r_pending))
        else $error("successful publish did not clear elapsed time");
`endif

endmodule

`default_nettype wire
